// ----- hw/rtl/slm_pkg.sv -----
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants of the sorted list merger.
// ----------------------------------------------------------------------------
`default_nettype none

package slm_pkg;

	localparam int LIST_DEPTH_DEF = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int VALUE_W        = 32;
	localparam int KIND_W         = 2;

	localparam logic [KIND_W-1:0] KIND_APPEND_A = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND_B = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MERGE    = 2'd2;

	typedef enum logic [1:0] {
		OP_APPEND_A,
		OP_APPEND_B,
		OP_MERGE
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
		logic                      empty_res;
		logic                      overflowed;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/slm_fifo.sv -----
// ----------------------------------------------------------------------------
// slm_fifo
// Small synchronous queue with full and empty flags, power-of-two depth.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_fifo import slm_pkg::*; #(
	parameter int WIDTH = VALUE_W,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/slm_front.sv -----
// ----------------------------------------------------------------------------
// slm_front
// Accepts input transactions, decodes the kind and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_front import slm_pkg::*; (
	input  wire logic                      push,
	output logic                           full,
	input  wire logic        [KIND_W-1:0]  kind,
	input  wire logic signed [VALUE_W-1:0] value,
	input  wire logic                      cmd_full,
	output logic                           cmd_push,
	output cmd_t                           cmd
);

	logic accept;
	logic known;

	assign full   = cmd_full;
	assign accept = push & ~cmd_full;

	always_comb begin
		cmd.value = value;
		cmd.op    = OP_MERGE;
		known     = 1'b1;
		unique case (kind)
			KIND_APPEND_A: cmd.op = OP_APPEND_A;
			KIND_APPEND_B: cmd.op = OP_APPEND_B;
			KIND_MERGE:    cmd.op = OP_MERGE;
			default:       known  = 1'b0;
		endcase
	end

	// unused kind is taken and dropped
	assign cmd_push = accept & known;

endmodule

`default_nettype wire

// ----- hw/rtl/slm_back.sv -----
// ----------------------------------------------------------------------------
// slm_back
// Holds both list stores and runs appends and the two-way merge.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_back import slm_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cmd_empty,
	input  wire cmd_t    cmd,
	output logic         cmd_pop,
	input  wire logic    res_full,
	output logic         res_push,
	output result_t      res
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic [VALUE_W-1:0] mem_a [LIST_DEPTH];
	logic [VALUE_W-1:0] mem_b [LIST_DEPTH];
	logic [VALUE_W-1:0] head_a_q;
	logic [VALUE_W-1:0] head_b_q;
	logic [CW-1:0]      cnt_a_q;
	logic [CW-1:0]      cnt_b_q;
	logic [CW-1:0]      idx_a_q;
	logic [CW-1:0]      idx_b_q;
	logic [CW-1:0]      next_a;
	logic [CW-1:0]      next_b;
	logic [AW-1:0]      addr_a;
	logic [AW-1:0]      addr_b;
	logic [CW:0]        taken;
	logic [CW:0]        total;
	logic               ovf_q;
	state_t             state_q;
	state_t             state_d;

	logic take_a;
	logic last_pick;
	logic wr_a;
	logic wr_b;
	logic set_ovf;
	logic start;
	logic done;
	logic adv_a;
	logic adv_b;

	assign take_a = (idx_a_q < cnt_a_q) &&
		((idx_b_q >= cnt_b_q) || ($signed(head_a_q) <= $signed(head_b_q)));
	assign taken     = {1'b0, idx_a_q} + {1'b0, idx_b_q} + (CW+1)'(1);
	assign total     = {1'b0, cnt_a_q} + {1'b0, cnt_b_q};
	assign last_pick = (taken == total);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_MERGE;
			ST_MERGE: if (done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '{value: '0, last: 1'b1, empty_res: 1'b1, overflowed: ovf_q};
		wr_a     = 1'b0;
		wr_b     = 1'b0;
		set_ovf  = 1'b0;
		start    = 1'b0;
		done     = 1'b0;
		adv_a    = 1'b0;
		adv_b    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					unique case (cmd.op)
						OP_APPEND_A: begin
							cmd_pop = 1'b1;
							wr_a    = (cnt_a_q < CW'(LIST_DEPTH));
							set_ovf = ~wr_a;
						end
						OP_APPEND_B: begin
							cmd_pop = 1'b1;
							wr_b    = (cnt_b_q < CW'(LIST_DEPTH));
							set_ovf = ~wr_b;
						end
						OP_MERGE: begin
							if (total == '0) begin
								res_push = ~res_full;
								cmd_pop  = res_push;
								done     = res_push;
							end else begin
								start = 1'b1;
							end
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			ST_MERGE: begin
				res_push = ~res_full;
				res      = '{value: take_a ? head_a_q : head_b_q, last: last_pick,
					empty_res: 1'b0, overflowed: ovf_q};
				adv_a    = res_push & take_a;
				adv_b    = res_push & ~take_a;
				done     = res_push & last_pick;
				cmd_pop  = done;
			end
			default: ;
		endcase
	end

	// read address runs one step ahead so the head is ready each cycle
	assign next_a = adv_a ? idx_a_q + CW'(1) : idx_a_q;
	assign next_b = adv_b ? idx_b_q + CW'(1) : idx_b_q;
	assign addr_a = next_a[AW-1:0];
	assign addr_b = next_b[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[cnt_a_q[AW-1:0]] <= cmd.value;
		end
		head_a_q <= mem_a[addr_a];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[cnt_b_q[AW-1:0]] <= cmd.value;
		end
		head_b_q <= mem_b[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			idx_a_q <= '0;
			idx_b_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				idx_a_q <= '0;
				idx_b_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				idx_a_q <= next_a;
				idx_b_q <= next_b;
				if (wr_a) begin
					cnt_a_q <= cnt_a_q + CW'(1);
				end
				if (wr_b) begin
					cnt_b_q <= cnt_b_q + CW'(1);
				end
				if (set_ovf) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_list_merger.sv -----
// ----------------------------------------------------------------------------
// sorted_list_merger
// Two-way merge of two ascending lists of signed 32-bit values.
// ----------------------------------------------------------------------------
// Appends to list A or B are carried out while the merge engine is idle; an
// append to a full list is dropped and flagged. A merge in which either list
// holds values first enters the merge state, then gives one result per cycle
// while the result queue is not full, since each store has a single read port
// that delivers the next head of its list every cycle; a merge of two empty
// lists gives one result marked empty_res. A two-entry command queue lets
// input transactions keep arriving while a merge drains, and a two-entry
// result queue holds results while pop is low. Ties take from list A.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_merger import slm_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic        [KIND_W-1:0]  kind,
	input  wire logic signed [VALUE_W-1:0] value,
	output logic                           empty,
	input  wire logic                      pop,
	output logic signed      [VALUE_W-1:0] merged_value,
	output logic                           last,
	output logic                           empty_res,
	output logic                           overflowed
);

	cmd_t    cmd_in;
	cmd_t    cmd_out;
	result_t res_in;
	result_t res_out;
	logic    cmd_push;
	logic    cmd_full;
	logic    cmd_pop;
	logic    cmd_empty;
	logic    res_push;
	logic    res_full;

	slm_front u_front (
		.push     (push),
		.full     (full),
		.kind     (kind),
		.value    (value),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	slm_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	slm_back #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	slm_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign merged_value = res_out.value;
	assign last         = res_out.last;
	assign empty_res    = res_out.empty_res;
	assign overflowed   = res_out.overflowed;

endmodule

`default_nettype wire
